// ----- hw/rtl/mbtc_pkg.sv -----
// Shared types, constants and pattern tables for the magic byte type classifier.
package mbtc_pkg;

   localparam int HEADER_BYTES_DEFAULT  = 512;
   localparam int PREFIX_WINDOW_DEFAULT = 64;

   localparam int NUM_MAGIC = 8;
   localparam int NUM_TEXT  = 4;
   localparam int TAR_BIT   = 8;
   localparam int TAR_AT    = 257;
   localparam int TAR_END   = 262;

   typedef enum logic [3:0] {
      TYPE_NONE = 4'd0,
      TYPE_PDF  = 4'd1,
      TYPE_PNG  = 4'd2,
      TYPE_JPEG = 4'd3,
      TYPE_7Z   = 4'd4,
      TYPE_ZIP  = 4'd5,
      TYPE_GZIP = 4'd6,
      TYPE_TAR  = 4'd7,
      TYPE_SVG  = 4'd8,
      TYPE_XML  = 4'd9,
      TYPE_HTML = 4'd10
   } type_code_type;

   // Match flags carried between headers bytes; counters live beside this struct.
   typedef struct packed {
      logic [8:0]  magic_alive;
      logic        skipping;
      logic [3:0]  prefix_alive;
      logic [23:0] recent;
      logic        svg_seen;
   } scan_flags_type;

   localparam scan_flags_type SCAN_FLAGS_RESET = '{
      magic_alive:  9'h1FF,
      skipping:     1'b1,
      prefix_alive: 4'hF,
      recent:       24'h000000,
      svg_seen:     1'b0
   };

   localparam logic [3:0] MAGIC_LEN [NUM_MAGIC] = '{
      4'd5, 4'd8, 4'd3, 4'd6, 4'd4, 4'd4, 4'd4, 4'd2
   };

   localparam logic [7:0] MAGIC_PAT [NUM_MAGIC][8] = '{
      '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00},
      '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
      '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h07, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam type_code_type MAGIC_CODE [NUM_MAGIC] = '{
      TYPE_PDF, TYPE_PNG, TYPE_JPEG, TYPE_7Z, TYPE_ZIP, TYPE_ZIP, TYPE_ZIP, TYPE_GZIP
   };

   // "ustar", padded so that any three-bit offset is a legal index.
   localparam logic [7:0] TAR_PAT [8] = '{
      8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00
   };

   localparam logic [3:0] TEXT_LEN [NUM_TEXT] = '{4'd5, 4'd4, 4'd14, 4'd5};

   // "<?xml", "<svg", "<!doctype html", "<html" after case folding.
   localparam logic [7:0] TEXT_PAT [NUM_TEXT][16] = '{
      '{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h73, 8'h76, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h21, 8'h64, 8'h6F, 8'h63, 8'h74, 8'h79, 8'h70,
        8'h65, 8'h20, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00},
      '{8'h3C, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // The three bytes that must precede a 'g' to complete "<svg".
   localparam logic [23:0] SVG_HEAD = 24'h3C7376;
   localparam logic [7:0]  CHAR_G   = 8'h67;

endpackage

// ----- hw/rtl/mbtc_scan.sv -----
// Next-state and type decision logic for one header byte of the classifier.
module mbtc_scan #(
   parameter int HEADER_BYTES  = mbtc_pkg::HEADER_BYTES_DEFAULT,
   parameter int PREFIX_WINDOW = mbtc_pkg::PREFIX_WINDOW_DEFAULT
) (
   input  logic [$clog2(HEADER_BYTES+1)-1:0]  cur_pos,
   input  logic [$clog2(PREFIX_WINDOW+1)-1:0] cur_count,
   input  mbtc_pkg::scan_flags_type           cur_flags,
   input  logic [7:0]                         data_byte,
   output logic [$clog2(HEADER_BYTES+1)-1:0]  nxt_pos,
   output logic [$clog2(PREFIX_WINDOW+1)-1:0] nxt_count,
   output mbtc_pkg::scan_flags_type           nxt_flags,
   output mbtc_pkg::type_code_type            type_code
);
   import mbtc_pkg::*;

   localparam int BP_W = $clog2(HEADER_BYTES+1);
   localparam int PC_W = $clog2(PREFIX_WINDOW+1);

   logic [BP_W-1:0] tar_off;
   logic [2:0]      tar_idx;
   logic [7:0]      folded;
   logic            is_space;

   assign tar_off  = cur_pos - BP_W'(TAR_AT);
   assign tar_idx  = tar_off[2:0];
   assign folded   = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'h20 : data_byte;
   assign is_space = (data_byte == 8'h20) || (data_byte == 8'h09) ||
                     (data_byte == 8'h0D) || (data_byte == 8'h0A);

   always_comb begin
      nxt_pos   = cur_pos;
      nxt_count = cur_count;
      nxt_flags = cur_flags;
      if (cur_pos < BP_W'(HEADER_BYTES)) begin
         for (int m = 0; m < NUM_MAGIC; m++) begin
            if (cur_pos < BP_W'(MAGIC_LEN[m]) && data_byte != MAGIC_PAT[m][cur_pos[2:0]]) begin
               nxt_flags.magic_alive[m] = 1'b0;
            end
         end
         if (cur_pos >= BP_W'(TAR_AT) && cur_pos < BP_W'(TAR_END) &&
             data_byte != TAR_PAT[tar_idx]) begin
            nxt_flags.magic_alive[TAR_BIT] = 1'b0;
         end
         // Leading whitespace is dropped before the text window opens.
         if (!(cur_flags.skipping && is_space)) begin
            nxt_flags.skipping = 1'b0;
            if (cur_count < PC_W'(PREFIX_WINDOW)) begin
               for (int k = 0; k < NUM_TEXT; k++) begin
                  if (cur_count < PC_W'(TEXT_LEN[k]) &&
                      folded != TEXT_PAT[k][cur_count[3:0]]) begin
                     nxt_flags.prefix_alive[k] = 1'b0;
                  end
               end
               if (folded == CHAR_G && cur_flags.recent == SVG_HEAD) begin
                  nxt_flags.svg_seen = 1'b1;
               end
               nxt_flags.recent = {cur_flags.recent[15:0], folded};
               nxt_count        = cur_count + PC_W'(1);
            end
         end
         nxt_pos = cur_pos + BP_W'(1);
      end
   end

   // Lowest priority is assigned first so that later, stronger matches override.
   always_comb begin
      type_code = TYPE_NONE;
      if ((nxt_flags.prefix_alive[2] && nxt_count >= PC_W'(TEXT_LEN[2])) ||
          (nxt_flags.prefix_alive[3] && nxt_count >= PC_W'(TEXT_LEN[3]))) begin
         type_code = TYPE_HTML;
      end
      if (nxt_flags.prefix_alive[1] && nxt_count >= PC_W'(TEXT_LEN[1])) begin
         type_code = TYPE_SVG;
      end
      if (nxt_flags.prefix_alive[0] && nxt_count >= PC_W'(TEXT_LEN[0])) begin
         type_code = nxt_flags.svg_seen ? TYPE_SVG : TYPE_XML;
      end
      if (nxt_flags.magic_alive[TAR_BIT] && nxt_pos >= BP_W'(TAR_END)) begin
         type_code = TYPE_TAR;
      end
      for (int m = NUM_MAGIC - 1; m >= 0; m--) begin
         if (nxt_flags.magic_alive[m] && nxt_pos >= BP_W'(MAGIC_LEN[m])) begin
            type_code = MAGIC_CODE[m];
         end
      end
   end

endmodule

// ----- hw/rtl/magic_byte_type_classifier.sv -----
// Top level of the magic byte type classifier: input register, scan state, result register.
//
// The request channel carries one header byte per transfer in req_tdata, with req_tlast
// high on the final byte of a header. Bytes are matched against the binary signatures
// (PDF, PNG, JPEG, 7Z, three ZIP variants, GZIP and "ustar" at offset 257) and, after
// leading whitespace is dropped and letters are folded to lowercase, against the text
// starts "<?xml", "<svg", "<!doctype html" and "<html" within the first PREFIX_WINDOW
// bytes. Bytes past HEADER_BYTES are ignored, but their last flag still ends the header.
// Only the request that carries tlast produces a response: one type code on rsp_tdata.
//
// A request is registered on acceptance and folded into the scan state when it leaves
// the input register; a final byte that leaves it loads the response register at that
// same edge. One request is taken every cycle; the only limit is the response register,
// which holds one type code until the receiver takes it. While the receiver stalls,
// ordinary bytes keep flowing in; a final byte waits in the input register until the
// response register is free, and req_tready stays low while it waits.
// After a response is produced all scan state returns to its reset value so the next
// request starts a new header. Reset empties both registers and clears the scan state.
module magic_byte_type_classifier #(
   parameter int HEADER_BYTES  = mbtc_pkg::HEADER_BYTES_DEFAULT,
   parameter int PREFIX_WINDOW = mbtc_pkg::PREFIX_WINDOW_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [3:0] type_code, [7:4] zero
);
   import mbtc_pkg::*;

   localparam int BP_W = $clog2(HEADER_BYTES+1);
   localparam int PC_W = $clog2(PREFIX_WINDOW+1);

   // Input register holding one accepted request.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Scan state for the header in progress.
   logic [BP_W-1:0] pos_ff, pos_in;
   logic [PC_W-1:0] count_ff, count_in;
   scan_flags_type  flags_ff, flags_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   type_code_type rsp_code_ff;

   logic [BP_W-1:0] scan_pos;
   logic [PC_W-1:0] scan_count;
   scan_flags_type  scan_flags;
   type_code_type   scan_code;

   logic out_free;
   logic s1_go;
   logic req_take;
   logic finish;

   mbtc_scan #(
      .HEADER_BYTES  (HEADER_BYTES),
      .PREFIX_WINDOW (PREFIX_WINDOW)
   ) u_scan (
      .cur_pos   (pos_ff),
      .cur_count (count_ff),
      .cur_flags (flags_ff),
      .data_byte (s1_byte_ff),
      .nxt_pos   (scan_pos),
      .nxt_count (scan_count),
      .nxt_flags (scan_flags),
      .type_code (scan_code)
   );

   // A final byte may leave the input register only when the response slot is free;
   // any other byte leaves at once.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign finish     = s1_go && s1_last_ff;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      if (finish) begin
         pos_in   = '0;
         count_in = '0;
         flags_in = SCAN_FLAGS_RESET;
      end else if (s1_go) begin
         pos_in   = scan_pos;
         count_in = scan_count;
         flags_in = scan_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         flags_ff     <= SCAN_FLAGS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (finish) begin
         rsp_code_ff <= scan_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_code_ff};

   // A final byte that leaves the input register always lands in the response register.
   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("final byte did not produce a response");

   // Every header restarts from a clean scan state after its response.
   a_finish_clears_state: assert property (@(posedge clock) disable iff (reset)
      finish |=> (pos_ff == '0 && count_ff == '0 && flags_ff == SCAN_FLAGS_RESET))
      else $error("scan state not cleared after a response");

   // The counters saturate at their limits.
   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= BP_W'(HEADER_BYTES)) && (count_ff <= PC_W'(PREFIX_WINDOW)) &&
      (BP_W'(count_ff) <= pos_ff))
      else $error("scan counter past its limit");

   // A response must never be overwritten before the receiver takes it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !finish)
      else $error("pending response overwritten");

endmodule

// ----- verif/mbtc_result_checker.sv -----
// Checker for the classifier: predicts the type code of every header and compares responses.
module mbtc_result_checker #(
   parameter int HEADER_BYTES  = mbtc_pkg::HEADER_BYTES_DEFAULT,
   parameter int PREFIX_WINDOW = mbtc_pkg::PREFIX_WINDOW_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // last_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [3:0] type_code, [7:4] zero
   output int         fail_count,
   output int         pending_count
);

   import mbtc_pkg::*;

   localparam int SIG_COUNT    = 8;
   localparam int TAR_FLAG     = 8;
   localparam int TAR_FIRST    = 257;
   localparam int TAR_STOP     = 262;
   localparam int REPORT_LIMIT = 10;

   localparam int START_XML     = 0;
   localparam int START_SVG     = 1;
   localparam int START_DOCTYPE = 2;
   localparam int START_HTML    = 3;

   // Binary signatures, first byte in element 0.
   localparam logic [0:7][7:0] SIG_BYTES [SIG_COUNT] = '{
      64'h255044462D000000,
      64'h89504E470D0A1A0A,
      64'hFFD8FF0000000000,
      64'h377ABCAF271C0000,
      64'h504B030400000000,
      64'h504B050600000000,
      64'h504B070800000000,
      64'h1F8B000000000000
   };
   localparam int SIG_BYTE_COUNT [SIG_COUNT] = '{5, 8, 3, 6, 4, 4, 4, 2};
   localparam type_code_type SIG_RESULT [SIG_COUNT] = '{
      TYPE_PDF, TYPE_PNG, TYPE_JPEG, TYPE_7Z, TYPE_ZIP, TYPE_ZIP, TYPE_ZIP, TYPE_GZIP
   };
   localparam logic [0:4][7:0] USTAR_BYTES = "ustar";

   // Text starts in lowercase, padded to the longest one.
   localparam logic [0:13][7:0] START_BYTES [4] = '{
      {"<?xml", 72'd0},
      {"<svg", 80'd0},
      "<!doctype html",
      {"<html", 72'd0}
   };
   localparam int START_BYTE_COUNT [4] = '{5, 4, 14, 5};

   int            header_pos;
   logic [8:0]    sig_alive;
   logic          leading_space;
   int            window_fill;
   logic [3:0]    start_alive;
   logic [23:0]   window_tail;
   logic          svg_in_window;
   type_code_type expected_type_codes [$];
   type_code_type next_expected;
   int            failures;
   int            reports;

   task automatic clear_scan();
      header_pos    = 0;
      sig_alive     = 9'h1FF;
      leading_space = 1'b1;
      window_fill   = 0;
      start_alive   = 4'hF;
      window_tail   = 24'd0;
      svg_in_window = 1'b0;
   endtask

   task automatic scan_header_byte(input logic [7:0] b);
      logic [7:0] c;
      if (header_pos < HEADER_BYTES) begin
         for (int m = 0; m < SIG_COUNT; m++) begin
            if (header_pos < SIG_BYTE_COUNT[m]) begin
               if (b != SIG_BYTES[m][header_pos]) sig_alive[m] = 1'b0;
            end
         end
         if (header_pos >= TAR_FIRST && header_pos < TAR_STOP) begin
            if (b != USTAR_BYTES[header_pos - TAR_FIRST]) sig_alive[TAR_FLAG] = 1'b0;
         end
         if (!(leading_space && (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A))) begin
            leading_space = 1'b0;
            if (window_fill < PREFIX_WINDOW) begin
               c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
               for (int k = 0; k < 4; k++) begin
                  if (window_fill < START_BYTE_COUNT[k]) begin
                     if (c != START_BYTES[k][window_fill]) start_alive[k] = 1'b0;
                  end
               end
               if (c == "g" && window_tail == "<sv") svg_in_window = 1'b1;
               window_tail = {window_tail[15:0], c};
               window_fill++;
            end
         end
         header_pos++;
      end
   endtask

   function automatic logic start_found(input int k);
      return start_alive[k] && window_fill >= START_BYTE_COUNT[k];
   endfunction

   function automatic type_code_type predict_type_code();
      for (int m = 0; m < SIG_COUNT; m++) begin
         if (sig_alive[m] && header_pos >= SIG_BYTE_COUNT[m]) return SIG_RESULT[m];
      end
      if (sig_alive[TAR_FLAG] && header_pos >= TAR_STOP) return TYPE_TAR;
      if (start_found(START_XML)) return svg_in_window ? TYPE_SVG : TYPE_XML;
      if (start_found(START_SVG)) return TYPE_SVG;
      if (start_found(START_DOCTYPE) || start_found(START_HTML)) return TYPE_HTML;
      return TYPE_NONE;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_type_codes.delete();
         failures = 0;
         reports  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_type_codes.size() == 0) begin
               failures++;
               if (reports < REPORT_LIMIT) begin
                  reports++;
                  $display("unexpected response: type code %0d, no header pending",
                           rsp_tdata[3:0]);
               end
            end else begin
               next_expected = expected_type_codes.pop_front();
               if (rsp_tdata[3:0] !== next_expected || rsp_tdata[7:4] !== 4'd0) begin
                  failures++;
                  if (reports < REPORT_LIMIT) begin
                     reports++;
                     $display("type code mismatch: expected %0d, got %0d (upper bits %h)",
                              next_expected, rsp_tdata[3:0], rsp_tdata[7:4]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            scan_header_byte(req_tdata);
            if (req_tlast) begin
               expected_type_codes.push_back(predict_type_code());
               clear_scan();
            end
         end
      end
      fail_count    <= failures;
      pending_count <= expected_type_codes.size();
   end

endmodule

// ----- verif/tb_magic_byte_type_classifier.sv -----
// Testbench top for the magic byte type classifier: clock, reset, header stimulus and verdict.
module tb_magic_byte_type_classifier;

   import mbtc_pkg::*;

   // Shapes of generated headers. Binary ones pick one of the eight signatures at random.
   typedef enum int {
      GEN_BINARY,
      GEN_XML,
      GEN_SVG,
      GEN_DOCTYPE,
      GEN_HTML,
      GEN_NOISE
   } header_kind_type;

   // Signature rows in the package table that the directed headers use.
   localparam int SIG_PDF       = 0;
   localparam int SIG_JPEG      = 2;
   localparam int SIG_ZIP_LOCAL = 4;
   localparam int SIG_GZIP      = 7;

   localparam int SHORT_BYTES_PER_PHASE = 60;
   localparam int DRAIN_LIMIT           = 2000;
   localparam int RUN_LIMIT             = 200000;

   localparam logic [7:0] WHITESPACE [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [3:0] type_code, [7:4] zero

   int fail_count;
   int pending_count;

   // Idle rates in percent of cycles; changed per phase by the stimulus process.
   int tx_idle_pct = 17;
   int rx_idle_pct = 66;

   // Bytes of the header currently being assembled, sent in order with tlast on the final one.
   logic [7:0] header_bytes [$];
   bit         drain_stuck = 1'b0;

   // Free running clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   magic_byte_type_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The checker follows both channels on its own and predicts every response.
   mbtc_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // The receiver decides anew at every falling edge whether it takes a response. With the
   // block holding only one type code, a stall here eventually holds back a final byte.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) header_bytes.push_back(8'($urandom));
   endtask

   task automatic push_space(input int count);
      for (int i = 0; i < count; i++) header_bytes.push_back(WHITESPACE[$urandom_range(0, 3)]);
   endtask

   // Appends the first count bytes of one of the binary signatures.
   task automatic push_signature(input int sig, input int count);
      for (int i = 0; i < count; i++) header_bytes.push_back(MAGIC_PAT[sig][i]);
   endtask

   // Appends text; with mixed set, every lowercase letter is raised to uppercase by chance,
   // which exercises the case folding of the text checks.
   task automatic push_pattern(input string text, input bit mixed);
      logic [7:0] c;
      for (int i = 0; i < text.len(); i++) begin
         c = text[i];
         if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'h20;
         header_bytes.push_back(c);
      end
   endtask

   // Sends the assembled header one request at a time. All signals change at the falling
   // edge; acceptance is read right after the rising edge, before the block updates.
   // While idle, the data lines carry junk so that a block that looks at them then is seen.
   task automatic send_header();
      for (int i = 0; i < header_bytes.size(); i++) begin
         while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom);
            req_tlast  <= 1'($urandom);
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= header_bytes[i];
         req_tlast  <= (i == header_bytes.size() - 1);
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
      end
      header_bytes.delete();
   endtask

   // Builds one short header. Most are well formed with random case, leading whitespace
   // and random tails; about a quarter are then broken by truncation or a flipped bit.
   task automatic build_short_header();
      header_kind_type kind;
      int              cut;
      int              spot;
      kind = header_kind_type'($urandom_range(0, 5));
      case (kind)
         GEN_BINARY: begin
            cut = $urandom_range(0, 7);
            push_signature(cut, MAGIC_LEN[cut]);
            push_random($urandom_range(0, 5));
         end
         GEN_XML: begin
            push_space($urandom_range(0, 3));
            push_pattern("<?xml", 1'b1);
            // An embedded svg tag turns XML into SVG only while it lies inside the window;
            // gaps above about 55 bytes push its end past the window.
            if ($urandom_range(0, 1) == 1) begin
               push_random($urandom_range(0, 60));
               push_pattern("<svg", 1'b1);
            end
            push_random($urandom_range(0, 4));
         end
         GEN_SVG: begin
            push_space($urandom_range(0, 3));
            push_pattern("<svg", 1'b1);
            push_random($urandom_range(0, 4));
         end
         GEN_DOCTYPE: begin
            push_space($urandom_range(0, 3));
            push_pattern("<!doctype html", 1'b1);
            push_random($urandom_range(0, 4));
         end
         GEN_HTML: begin
            push_space($urandom_range(0, 3));
            push_pattern("<html", 1'b1);
            push_random($urandom_range(0, 4));
         end
         default: begin
            push_random($urandom_range(1, 6));
         end
      endcase
      if ($urandom_range(0, 3) == 0 && header_bytes.size() > 1) begin
         if ($urandom_range(0, 1) == 1) begin
            cut = $urandom_range(1, header_bytes.size() - 1);
            while (header_bytes.size() > cut) void'(header_bytes.pop_back());
         end else begin
            spot = $urandom_range(0, header_bytes.size() - 1);
            header_bytes[spot] = header_bytes[spot] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
   endtask

   // Holds the sender back until every expected response has been taken.
   task automatic wait_until_drained();
      int cycles;
      cycles = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 && cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         cycles++;
      end
      if (pending_count != 0) drain_stuck = 1'b1;
   endtask

   // Hard limit on the whole run, far above the slowest correct run.
   initial begin
      #(RUN_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int sent;
      int spot;

      // Synchronous reset is held from the start, then released at a falling edge.
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed headers: single extreme bytes, signatures of two to five bytes, a short
      // signature that must not match, and an svg start behind leading whitespace.
      header_bytes.push_back(8'hFF);
      send_header();
      header_bytes.push_back(8'h00);
      send_header();
      push_signature(SIG_GZIP, 2);
      send_header();
      push_signature(SIG_JPEG, 3);
      send_header();
      push_signature(SIG_ZIP_LOCAL, 4);
      send_header();
      push_signature(SIG_PDF, 5);
      send_header();
      push_signature(SIG_JPEG, 2);
      send_header();
      push_space(1);
      push_pattern("<svg", 1'b1);
      send_header();

      for (int phase = 0; phase < 3; phase++) begin
         // The sender pauses here until the block has nothing left to report.
         wait_until_drained();
         case (phase)
            0: begin
               tx_idle_pct = 17;
               rx_idle_pct = 66;
            end
            1: begin
               tx_idle_pct = 66;
               rx_idle_pct = 17;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase

         // One long header per phase: a valid tar marker, a tar marker possibly broken,
         // and whitespace that runs up to the header limit so that an html start behind
         // it runs past the limit and is not recognised.
         case (phase)
            0: begin
               push_random(TAR_AT);
               push_pattern("ustar", 1'b0);
               push_random($urandom_range(0, 4));
            end
            1: begin
               push_random(TAR_AT);
               push_pattern("ustar", 1'b0);
               if ($urandom_range(0, 1) == 1) begin
                  spot = TAR_AT + $urandom_range(0, 4);
                  header_bytes[spot] = header_bytes[spot] ^ (8'h01 << $urandom_range(0, 7));
               end
            end
            default: begin
               push_space(HEADER_BYTES_DEFAULT - $urandom_range(0, 3));
               push_pattern("<html", 1'b1);
            end
         endcase
         send_header();

         sent = 0;
         while (sent < SHORT_BYTES_PER_PHASE) begin
            build_short_header();
            sent += header_bytes.size();
            send_header();
         end
      end

      // Let the last responses come out, then allow a few more cycles for any stray one.
      wait_until_drained();
      if (drain_stuck) begin
         $display("FAILED: results differ");
      end else begin
         repeat (8) @(negedge clock);
         if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
         end else begin
            $display("FAILED: results differ");
         end
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mbtc_pkg.sv
hw/rtl/mbtc_scan.sv
hw/rtl/magic_byte_type_classifier.sv
verif/mbtc_result_checker.sv
verif/tb_magic_byte_type_classifier.sv
